// ----- hdl/clipped_alpha_blend_blit_unit_macros.svh -----
// ---------------------------------------------------------------------------
// clipped alpha blend blit unit: assertion macros
// shared property forms for the blit unit checks
// ---------------------------------------------------------------------------
`ifndef CLIPPED_ALPHA_BLEND_BLIT_UNIT_MACROS_SVH
`define CLIPPED_ALPHA_BLEND_BLIT_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define CABB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cabb implication check failed");

// next-cycle implication, checked out of reset
`define CABB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cabb next-cycle check failed");

`endif

// ----- hdl/cabb_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cabb_pkg
// types, register codes and helpers shared by the blit unit modules
// ---------------------------------------------------------------------------
package cabb_pkg;

  // config register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_SCREEN_W = 3'd0;
  localparam logic [2:0] REG_SCREEN_H = 3'd1;
  localparam logic [2:0] REG_IMAGE_W  = 3'd2;
  localparam logic [2:0] REG_IMAGE_H  = 3'd3;
  localparam logic [2:0] REG_PLACE_X  = 3'd4;
  localparam logic [2:0] REG_PLACE_Y  = 3'd5;

  localparam int CoordW = 13;
  localparam int IdxW   = 24;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [IdxW-1:0]   idx_t;

  // clipped window, as seen by the blit state logic
  typedef struct packed {
    logic   empty;
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
    idx_t   first_idx;
  } clip_t;

  // dimension register limited to the maximum dimension
  function automatic logic [13:0] dim_clamp(input coord_t v, input logic [13:0] lim);
    logic [13:0] ext;
    ext = {1'b0, v};
    return (ext > lim) ? lim : ext;
  endfunction

endpackage

// ----- hdl/cabb_clip.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cabb_clip
// clips the placed image against the screen and finds the first source index
// ---------------------------------------------------------------------------
module cabb_clip #(
  parameter int MAX_DIM = 4096
) (
  input  cabb_pkg::coord_t    screen_width,
  input  cabb_pkg::coord_t    screen_height,
  input  cabb_pkg::coord_t    image_width,
  input  cabb_pkg::coord_t    image_height,
  input  logic signed [13:0]  place_x,
  input  logic signed [13:0]  place_y,
  output cabb_pkg::clip_t     clip
);
  import cabb_pkg::*;

  localparam logic [13:0] DimLim = 14'(MAX_DIM);

  logic [13:0]        iw, ih, sw, sh;
  logic signed [15:0] maxx, maxy, maxx_c, maxy_c;
  logic signed [15:0] minx_c, miny_c;
  logic [13:0]        offx;
  logic signed [15:0] row_s;
  logic [26:0]        row_prod;

  // clamp dimensions
  assign iw = dim_clamp(image_width, DimLim);
  assign ih = dim_clamp(image_height, DimLim);
  assign sw = dim_clamp(screen_width, DimLim);
  assign sh = dim_clamp(screen_height, DimLim);

  // raw extents, then clip to the screen
  always_comb begin
    maxx   = 16'(place_x) + $signed({2'b00, iw});
    maxy   = 16'(place_y) + $signed({2'b00, ih});
    minx_c = place_x[13] ? 16'sd0 : 16'(place_x);
    miny_c = place_y[13] ? 16'sd0 : 16'(place_y);
    offx   = place_x[13] ? 14'(-place_x) : 14'd0;
    maxx_c = (maxx > $signed({2'b00, sw})) ? $signed({2'b00, sw}) : maxx;
    maxy_c = (maxy > $signed({2'b00, sh})) ? $signed({2'b00, sh}) : maxy;
    // bottom-up source: row of the window top counted from the buffer start
    row_s  = $signed({2'b00, ih}) - 16'sd1 + (place_y[13] ? 16'(place_y) : 16'sd0);
  end

  assign row_prod = iw * row_s[12:0];

  // window result; fields are zero when the window is empty
  always_comb begin
    clip.empty = !((minx_c < maxx_c) && (miny_c < maxy_c));
    if (clip.empty) begin
      clip.left      = '0;
      clip.top       = '0;
      clip.right     = '0;
      clip.bottom    = '0;
      clip.first_idx = '0;
    end else begin
      clip.left      = minx_c[CoordW-1:0];
      clip.top       = miny_c[CoordW-1:0];
      clip.right     = maxx_c[CoordW-1:0];
      clip.bottom    = maxy_c[CoordW-1:0];
      clip.first_idx = row_prod[IdxW-1:0] + {10'b0, offx};
    end
  end

endmodule

// ----- hdl/cabb_blend.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cabb_blend
// source-over blend of R, G and B with 8-bit source alpha, alpha out 0xFF
// ---------------------------------------------------------------------------
module cabb_blend (
  input  logic [31:0] src_pixel,
  input  logic [31:0] dst_pixel,
  output logic [31:0] pixel_out
);
  import cabb_pkg::*;

  // round(a*s + (255-a)*d) / 255, done as floor((sum + 127) / 255)
  // the divide is a multiply by 0x8081 (shift-add) and a shift by 23
  function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] s,
                                     input logic [7:0] d);
    logic signed [8:0]  diff;
    logic signed [17:0] prod;
    logic signed [17:0] sum;
    logic [16:0]        t;
    logic [32:0]        q;
    diff = $signed({1'b0, s}) - $signed({1'b0, d});
    prod = $signed({1'b0, a}) * diff;
    sum  = $signed({2'b00, d, 8'h00}) - $signed({10'b0, d}) + prod;
    t    = 17'(sum[15:0]) + 17'd127;
    q    = {16'b0, t} + {9'b0, t, 7'b0} + {1'b0, t, 15'b0};
    return q[30:23];
  endfunction

  logic [7:0] alpha;

  assign alpha = src_pixel[31:24];

  // per-channel blend, alpha byte forced opaque
  always_comb begin
    pixel_out[31:24] = 8'hFF;
    for (int c = 0; c < 3; c++) begin
      pixel_out[8*c +: 8] = mix(alpha, src_pixel[8*c +: 8], dst_pixel[8*c +: 8]);
    end
  end

endmodule

// ----- hdl/clipped_alpha_blend_blit_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clipped_alpha_blend_blit_unit
// places a bottom-up 32-bit image on a screen, clipped, and blends pixels
// ---------------------------------------------------------------------------
// The unit takes one beat per clock while the output is not stalled and
// returns one result beat for each input beat, held in the input register
// and then, past the clip/blend logic, in the result register. An
// open-window beat (op 0) clips the placed image to the screen and reports
// the window and first source index; each pixel beat (op 1) taken while a
// window is open blends one source/destination pair in raster order and
// reports its coordinates and source index. Back pressure on the output
// stalls both stages; input ready drops only when the input register is
// full and the result register cannot drain. The user must write registers
// over the APB-style port only while no beat is in flight; not enforced.
// ---------------------------------------------------------------------------
`include "clipped_alpha_blend_blit_unit_macros.svh"

module clipped_alpha_blend_blit_unit #(
  parameter int MAX_DIM = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // [31:0] src_pixel, [63:32] dst_pixel
  input  logic         in_tuser,   // [0] op
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] pixel_out, [44:32] dest_x, [57:45] dest_y, [70:58] dest_end_x,
  // [83:71] dest_end_y, [107:84] source_index, [111:108] zero
  output logic [111:0] out_tdata,
  output logic         out_tlast,  // last_in_window
  output logic         out_tuser,  // [0] window_empty
  // configuration port
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import cabb_pkg::*;

  localparam logic [13:0] DimLim = 14'(MAX_DIM);

  // config registers
  coord_t             screen_width_r, screen_height_r, image_width_r, image_height_r;
  logic signed [13:0] place_x_r, place_y_r;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  // blit state
  coord_t window_left_r, window_right_r, window_bottom_r;
  coord_t cursor_x_r, cursor_y_r;
  idx_t   row_source_start_r;
  logic   blit_open_r;
  coord_t window_left_nxt, window_right_nxt, window_bottom_nxt;
  coord_t cursor_x_nxt, cursor_y_nxt;
  idx_t   row_source_start_nxt;
  logic   blit_open_nxt;

  // input register
  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_op_r;
  logic [31:0] s1_src_r, s1_dst_r;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] res_pixel_r, res_pixel_nxt;
  coord_t      res_x_r, res_x_nxt, res_y_r, res_y_nxt;
  coord_t      res_ex_r, res_ex_nxt, res_ey_r, res_ey_nxt;
  idx_t        res_idx_r, res_idx_nxt;
  logic        res_last_r, res_last_nxt;
  logic        res_empty_r, res_empty_nxt;

  logic        adv;
  logic        fire;
  clip_t       clip;
  logic [31:0] blend_pix;
  logic        row_end, last_px;
  logic [13:0] iw_dim;

  // configuration write and read
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= '0;
      screen_height_r <= '0;
      image_width_r   <= '0;
      image_height_r  <= '0;
      place_x_r       <= '0;
      place_y_r       <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SCREEN_W: screen_width_r  <= cfg_pwdata[CoordW-1:0];
        REG_SCREEN_H: screen_height_r <= cfg_pwdata[CoordW-1:0];
        REG_IMAGE_W:  image_width_r   <= cfg_pwdata[CoordW-1:0];
        REG_IMAGE_H:  image_height_r  <= cfg_pwdata[CoordW-1:0];
        REG_PLACE_X:  place_x_r       <= $signed(cfg_pwdata[13:0]);
        REG_PLACE_Y:  place_y_r       <= $signed(cfg_pwdata[13:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SCREEN_W: cfg_prdata = {19'b0, screen_width_r};
      REG_SCREEN_H: cfg_prdata = {19'b0, screen_height_r};
      REG_IMAGE_W:  cfg_prdata = {19'b0, image_width_r};
      REG_IMAGE_H:  cfg_prdata = {19'b0, image_height_r};
      REG_PLACE_X:  cfg_prdata = {18'b0, place_x_r};
      REG_PLACE_Y:  cfg_prdata = {18'b0, place_y_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // pipeline flow control
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv;
  assign fire      = s1_valid_r && adv;

  always_comb begin
    s1_valid_nxt  = in_tready ? in_tvalid : s1_valid_r;
    out_valid_nxt = adv ? s1_valid_r : out_valid_r;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_tvalid && in_tready) begin
      s1_op_r  <= in_tuser;
      s1_src_r <= in_tdata[31:0];
      s1_dst_r <= in_tdata[63:32];
    end
  end

  // window clipping and pixel blend
  cabb_clip #(
    .MAX_DIM(MAX_DIM)
  ) u_clip (
    .screen_width (screen_width_r),
    .screen_height(screen_height_r),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .place_x      (place_x_r),
    .place_y      (place_y_r),
    .clip         (clip)
  );

  cabb_blend u_blend (
    .src_pixel(s1_src_r),
    .dst_pixel(s1_dst_r),
    .pixel_out(blend_pix)
  );

  // cursor position within the window
  assign iw_dim  = dim_clamp(image_width_r, DimLim);
  assign row_end = ({1'b0, cursor_x_r} + 14'd1) >= {1'b0, window_right_r};
  assign last_px = row_end && (({1'b0, cursor_y_r} + 14'd1) >= {1'b0, window_bottom_r});

  // state update and result for the beat in the input register
  always_comb begin
    window_left_nxt      = window_left_r;
    window_right_nxt     = window_right_r;
    window_bottom_nxt    = window_bottom_r;
    cursor_x_nxt         = cursor_x_r;
    cursor_y_nxt         = cursor_y_r;
    row_source_start_nxt = row_source_start_r;
    blit_open_nxt        = blit_open_r;

    res_pixel_nxt = s1_dst_r;
    res_x_nxt     = '0;
    res_y_nxt     = '0;
    res_ex_nxt    = '0;
    res_ey_nxt    = '0;
    res_idx_nxt   = '0;
    res_last_nxt  = 1'b0;
    res_empty_nxt = 1'b1;

    if (!s1_op_r) begin
      // open a blit window
      res_empty_nxt = clip.empty;
      res_x_nxt     = clip.left;
      res_y_nxt     = clip.top;
      res_ex_nxt    = clip.right;
      res_ey_nxt    = clip.bottom;
      res_idx_nxt   = clip.first_idx;
      blit_open_nxt = !clip.empty;
      if (!clip.empty) begin
        window_left_nxt      = clip.left;
        window_right_nxt     = clip.right;
        window_bottom_nxt    = clip.bottom;
        cursor_x_nxt         = clip.left;
        cursor_y_nxt         = clip.top;
        row_source_start_nxt = clip.first_idx;
      end
    end else if (blit_open_r) begin
      // blend one pixel pair and step the cursor
      res_pixel_nxt = blend_pix;
      res_empty_nxt = 1'b0;
      res_x_nxt     = cursor_x_r;
      res_y_nxt     = cursor_y_r;
      res_ex_nxt    = window_right_r;
      res_ey_nxt    = window_bottom_r;
      res_idx_nxt   = row_source_start_r + {11'b0, cursor_x_r - window_left_r};
      res_last_nxt  = last_px;
      if (last_px) begin
        blit_open_nxt = 1'b0;
      end else if (row_end) begin
        cursor_x_nxt         = window_left_r;
        cursor_y_nxt         = cursor_y_r + 13'd1;
        row_source_start_nxt = row_source_start_r - {10'b0, iw_dim};
      end else begin
        cursor_x_nxt = cursor_x_r + 13'd1;
      end
    end
  end

  // blit state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_left_r      <= '0;
      window_right_r     <= '0;
      window_bottom_r    <= '0;
      cursor_x_r         <= '0;
      cursor_y_r         <= '0;
      row_source_start_r <= '0;
      blit_open_r        <= 1'b0;
    end else if (fire) begin
      window_left_r      <= window_left_nxt;
      window_right_r     <= window_right_nxt;
      window_bottom_r    <= window_bottom_nxt;
      cursor_x_r         <= cursor_x_nxt;
      cursor_y_r         <= cursor_y_nxt;
      row_source_start_r <= row_source_start_nxt;
      blit_open_r        <= blit_open_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (fire) begin
      res_pixel_r <= res_pixel_nxt;
      res_x_r     <= res_x_nxt;
      res_y_r     <= res_y_nxt;
      res_ex_r    <= res_ex_nxt;
      res_ey_r    <= res_ey_nxt;
      res_idx_r   <= res_idx_nxt;
      res_last_r  <= res_last_nxt;
      res_empty_r <= res_empty_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, res_idx_r, res_ey_r, res_ex_r, res_y_r, res_x_r, res_pixel_r};
  assign out_tlast  = res_last_r;
  assign out_tuser  = res_empty_r;

  // checks
  `CABB_ASSERT_IMP(a_cursor_in_window, blit_open_r, (cursor_x_r < window_right_r) && (cursor_y_r < window_bottom_r))
  `CABB_ASSERT_NXT(a_close_after_last, fire && s1_op_r && blit_open_r && last_px, !blit_open_r)
  `CABB_ASSERT_IMP(a_last_not_empty, out_valid_r && res_last_r, !res_empty_r && (res_pixel_r[31:24] == 8'hFF))

endmodule
